@@ hdl/pn3_pkg.sv @@
// pn3_pkg: shared types and constants for the 3d noise evaluator
// no dependencies
package pn3_pkg;

   localparam int TABLE_SIZE_DEF = 256;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int OUT_BITS       = 17;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_EVAL = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MOD,
      ST_FADE,
      ST_RD1,
      ST_RD2,
      ST_RD3,
      ST_GRAD,
      ST_LERP,
      ST_OUT,
      ST_LOAD2
   } state_type;

endpackage

@@ hdl/perlin_noise_3d_eval.sv @@
// perlin_noise_3d_eval: improved 3d perlin noise at a fixed-point point
// depends on pn3_pkg
// Flow: a load word with an index inside the table makes a direct and a
// mirrored write on the single table port. An evaluate word runs these steps
// in order: a wrap step that subtracts the effective repeat, in parallel on
// each axis at or above it, until every integer part is below it; a fade of
// three multiplies per axis, one axis after another; 8 corners of 3 chained
// table reads plus a gradient step each; 7 lerps of one shared multiply each;
// an output step. The steps run in turn on the single table port and the one
// shared multiplier. The hash table has no reset and must be loaded before
// use; the block takes no word while busy. The result is held in an output
// register until taken; a new word may be taken while it waits, and the
// output cycle of that word stalls until the register is free.
module perlin_noise_3d_eval #(
   parameter int TABLE_SIZE = pn3_pkg::TABLE_SIZE_DEF,
   parameter int FRAC_BITS  = pn3_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // x_coord, y_coord, z_coord, entry_index, entry_value (112 bits)
   input  logic [111:0] req_tdata,
   // func
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // noise_value, zero filled
   output logic [23:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_data
);

   localparam int AW = $clog2(2 * TABLE_SIZE);
   localparam int IW = $clog2(TABLE_SIZE) + 1;
   localparam int F  = FRAC_BITS;
   localparam int VW = F + 6;
   localparam int PW = 2 * VW;
   localparam int OVW = VW + 18;
   localparam int OS = F + 1 - 16;
   localparam int SR = (OS > 0) ? OS : 0;
   localparam int SL = (OS < 0) ? -OS : 0;
   localparam int RH = (1 << SR) >> 1;
   localparam int OUT_W = pn3_pkg::OUT_BITS;
   localparam logic signed [VW-1:0] ONE = VW'(1) << F;

   pn3_pkg::state_type state_ff, state_in;

   logic [8:0]  repeat_ff;
   logic [7:0]  mem [0:2*TABLE_SIZE-1];
   logic [7:0]  rd_ff;
   logic [AW-1:0] addr;
   logic        we;
   logic [7:0]  wdata;

   logic [IW-1:0] rep;
   logic [31:0] ip_ff [3];
   logic [F-1:0] fr_ff [3];
   logic signed [VW-1:0] fd_ff [3];
   logic [1:0]  ax_ff;
   logic [1:0]  fs_ff;
   logic signed [VW-1:0] t2_ff, t3_ff;
   logic [2:0]  cn_ff;
   logic signed [VW-1:0] g_ff [8];
   logic [2:0]  lp_ff;
   logic signed [VW-1:0] n_ff;
   logic [7:0]  eidx_ff, eval_ff;
   logic [OUT_W-1:0] out_ff;
   logic        out_v_ff;
   logic        out_free;

   // shared multiplier
   logic signed [VW-1:0] ma, mb;
   logic signed [PW-1:0] mp, mr;
   assign mp = PW'(ma) * PW'(mb);
   logic signed [PW-1:0] mh;
   assign mh = mp + (PW'(1) <<< (F - 1));
   assign mr = mh >>> F;

   assign rep = (repeat_ff == 9'd0) ? IW'(1) :
                ({23'd0, repeat_ff} > 32'(TABLE_SIZE)) ? IW'(TABLE_SIZE) : IW'(repeat_ff);

   assign out_free = !out_v_ff || rsp_tready;
   assign req_tready = (state_ff == pn3_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = {{(24-OUT_W){1'b0}}, out_ff};

   logic acc;
   assign acc = req_tvalid && req_tready;

   // corner coordinates
   logic [IW-1:0] cidx;
   logic [IW-1:0] ci [3];
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         if (cn_ff[a]) begin
            ci[a] = (IW'(ip_ff[a]) + IW'(1) >= rep) ? IW'(0) : IW'(ip_ff[a]) + IW'(1);
         end else begin
            ci[a] = IW'(ip_ff[a]);
         end
      end
      cidx = ci[0];
   end

   // grad
   logic signed [VW-1:0] gx, gy, gz, gv;
   always_comb begin
      gx = cn_ff[0] ? VW'(fr_ff[0]) - ONE : VW'(fr_ff[0]);
      gy = cn_ff[1] ? VW'(fr_ff[1]) - ONE : VW'(fr_ff[1]);
      gz = cn_ff[2] ? VW'(fr_ff[2]) - ONE : VW'(fr_ff[2]);
      case (rd_ff[3:0])
         4'h0: gv = gx + gy;
         4'h1: gv = -gx + gy;
         4'h2: gv = gx - gy;
         4'h3: gv = -gx - gy;
         4'h4: gv = gx + gz;
         4'h5: gv = -gx + gz;
         4'h6: gv = gx - gz;
         4'h7: gv = -gx - gz;
         4'h8: gv = gy + gz;
         4'h9: gv = -gy + gz;
         4'hA: gv = gy - gz;
         4'hB: gv = -gy - gz;
         4'hC: gv = gy + gx;
         4'hD: gv = -gy + gz;
         4'hE: gv = gy - gx;
         default: gv = -gy - gz;
      endcase
   end

   // lerp operand selection: 0..3 x lerps, 4..5 y, 6 z
   logic signed [VW-1:0] la, lb, lw;
   always_comb begin
      case (lp_ff)
         3'd0: begin la = g_ff[0]; lb = g_ff[1]; lw = fd_ff[0]; end
         3'd1: begin la = g_ff[2]; lb = g_ff[3]; lw = fd_ff[0]; end
         3'd2: begin la = g_ff[4]; lb = g_ff[5]; lw = fd_ff[0]; end
         3'd3: begin la = g_ff[6]; lb = g_ff[7]; lw = fd_ff[0]; end
         3'd4: begin la = g_ff[0]; lb = g_ff[1]; lw = fd_ff[1]; end
         3'd5: begin la = g_ff[2]; lb = g_ff[3]; lw = fd_ff[1]; end
         default: begin la = g_ff[0]; lb = g_ff[2]; lw = fd_ff[2]; end
      endcase
   end

   logic signed [VW-1:0] p_val;
   logic signed [VW-1:0] fcur;
   assign fcur = VW'(fr_ff[ax_ff]);
   assign p_val = VW'(6 * t2_ff - 15 * fcur + 10 * ONE);

   always_comb begin
      ma = '0;
      mb = '0;
      case (state_ff)
         pn3_pkg::ST_FADE: begin
            case (fs_ff)
               2'd0: begin ma = fcur; mb = fcur; end
               2'd1: begin ma = t2_ff; mb = fcur; end
               default: begin
                  ma = t3_ff;
                  mb = (p_val < 0) ? '0 : p_val;
               end
            endcase
         end
         pn3_pkg::ST_LERP: begin ma = lb - la; mb = lw; end
         default: begin ma = '0; mb = '0; end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pn3_pkg::ST_IDLE: begin
            if (acc) begin
               if (req_tuser == pn3_pkg::FUNC_EVAL) state_in = pn3_pkg::ST_MOD;
               else if (32'(req_tdata[103:96]) < 32'(TABLE_SIZE))
                  state_in = pn3_pkg::ST_LOAD2;
            end
         end
         pn3_pkg::ST_LOAD2: state_in = pn3_pkg::ST_IDLE;
         pn3_pkg::ST_MOD: begin
            if (ip_ff[0] < 32'(rep) && ip_ff[1] < 32'(rep) && ip_ff[2] < 32'(rep))
               state_in = pn3_pkg::ST_FADE;
         end
         pn3_pkg::ST_FADE: begin
            if (fs_ff == 2'd2 && ax_ff == 2'd2) state_in = pn3_pkg::ST_RD1;
         end
         pn3_pkg::ST_RD1: state_in = pn3_pkg::ST_RD2;
         pn3_pkg::ST_RD2: state_in = pn3_pkg::ST_RD3;
         pn3_pkg::ST_RD3: state_in = pn3_pkg::ST_GRAD;
         pn3_pkg::ST_GRAD: begin
            state_in = (cn_ff == 3'd7) ? pn3_pkg::ST_LERP : pn3_pkg::ST_RD1;
         end
         pn3_pkg::ST_LERP: if (lp_ff == 3'd6) state_in = pn3_pkg::ST_OUT;
         pn3_pkg::ST_OUT: if (out_free) state_in = pn3_pkg::ST_IDLE;
         default: state_in = pn3_pkg::ST_IDLE;
      endcase
   end

   // memory port
   always_comb begin
      we = 1'b0;
      wdata = eval_ff;
      addr = '0;
      case (state_ff)
         pn3_pkg::ST_IDLE: begin
            we = acc && (req_tuser == pn3_pkg::FUNC_LOAD)
                 && (32'(req_tdata[103:96]) < 32'(TABLE_SIZE));
            wdata = req_tdata[111:104];
            addr = AW'(req_tdata[103:96]);
         end
         pn3_pkg::ST_LOAD2: begin
            we = 1'b1;
            addr = AW'(32'(eidx_ff) + 32'(rep));
         end
         pn3_pkg::ST_RD1: addr = AW'(cidx);
         pn3_pkg::ST_RD2: addr = AW'(({1'b0, IW'(0)} | (IW+1)'(rd_ff)) + (IW+1)'(ci[1]));
         pn3_pkg::ST_RD3: addr = AW'(({1'b0, IW'(0)} | (IW+1)'(rd_ff)) + (IW+1)'(ci[2]));
         default: addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rd_ff <= mem[addr];
   end

   logic signed [PW-1:0] fd_c;
   assign fd_c = (mr < 0) ? '0 : (mr > PW'(ONE)) ? PW'(ONE) : mr;

   logic signed [VW-1:0] lres;
   assign lres = la + VW'(mr);

   logic signed [VW+1:0] sh;
   logic signed [OVW-1:0] ov;
   assign sh = ((VW+2)'(n_ff) + (VW+2)'(ONE));
   assign ov = ((OVW'(sh) + OVW'(RH)) >>> SR) <<< SL;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pn3_pkg::ST_IDLE;
         repeat_ff <= 9'd256;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) repeat_ff <= csr_data;
         if (state_ff == pn3_pkg::ST_OUT && out_free) out_v_ff <= 1'b1;
         else if (rsp_tready) out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         pn3_pkg::ST_IDLE: begin
            eidx_ff <= req_tdata[103:96];
            eval_ff <= req_tdata[111:104];
            for (int a = 0; a < 3; a++) begin
               ip_ff[a] <= req_tdata[32*a +: 32] >> F;
               fr_ff[a] <= req_tdata[32*a +: F];
            end
            ax_ff <= 2'd0;
            fs_ff <= 2'd0;
            cn_ff <= 3'd0;
            lp_ff <= 3'd0;
         end
         pn3_pkg::ST_MOD: begin
            for (int a = 0; a < 3; a++)
               if (ip_ff[a] >= 32'(rep)) ip_ff[a] <= ip_ff[a] - 32'(rep);
         end
         pn3_pkg::ST_FADE: begin
            case (fs_ff)
               2'd0: begin t2_ff <= VW'(mr); fs_ff <= 2'd1; end
               2'd1: begin t3_ff <= VW'(mr); fs_ff <= 2'd2; end
               default: begin
                  fd_ff[ax_ff] <= VW'(fd_c);
                  fs_ff <= 2'd0;
                  ax_ff <= ax_ff + 2'd1;
               end
            endcase
         end
         pn3_pkg::ST_GRAD: begin
            g_ff[{cn_ff[2], cn_ff[1], cn_ff[0]}] <= gv;
            cn_ff <= cn_ff + 3'd1;
         end
         pn3_pkg::ST_LERP: begin
            case (lp_ff)
               3'd0: g_ff[0] <= lres;
               3'd1: g_ff[1] <= lres;
               3'd2: g_ff[2] <= lres;
               3'd3: g_ff[3] <= lres;
               3'd4: g_ff[0] <= lres;
               3'd5: g_ff[2] <= lres;
               default: n_ff <= lres;
            endcase
            lp_ff <= lp_ff + 3'd1;
         end
         pn3_pkg::ST_OUT: begin
            if (out_free) begin
               if (ov < 0) out_ff <= '0;
               else if (ov > OVW'(65536)) out_ff <= OUT_W'(65536);
               else out_ff <= OUT_W'(ov);
            end
         end
         default: ;
      endcase
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !rsp_tready |=> out_v_ff && $stable(out_ff))
      else $error("result changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      state_ff != pn3_pkg::ST_IDLE |-> !req_tready)
      else $error("ready while busy");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> out_ff <= OUT_W'(65536))
      else $error("noise out of range");
`endif

endmodule
